FILE: rtl/core/psa_pkg.sv
`default_nettype none
package psa_pkg;

  localparam int MAX_TASKS_DEF  = 64;
  localparam int LEVELS_DEF     = 4;
  localparam int TICK_WIDTH_DEF = 16;

  localparam logic       PREEMPTIVE_RST  = 1'b1;
  localparam logic [7:0] AGING_WAIT_RST  = 8'd5;
  localparam logic [15:0] ADMIT_LIMIT_RST = 16'd100;

  localparam logic [6:0] CNT_MAX = 7'd127;

  // register indexes on the config port
  localparam logic [1:0] REG_PREEMPTIVE  = 2'd0;
  localparam logic [1:0] REG_AGING_WAIT  = 2'd1;
  localparam logic [1:0] REG_ADMIT_LIMIT = 2'd2;

  // item kinds
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [5:0] task_id;
    logic [2:0] level;
    logic [4:0] service_quanta;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        idle;
    logic [5:0]  run_id;
    logic [2:0]  run_level;
    logic        first_run;
    logic        finished;
    logic [6:0]  promoted;
    logic [6:0]  dropped;
    logic        all_done;
    logic [15:0] tick_now;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/priority_scheduler_with_aging_core.sv
`default_nettype none
// Multilevel priority scheduler with aging.
// Input channel (in_valid/in_stall/in_data): an arrival item enqueues a task
// at the tail of its level; a tick item ages, picks and runs one quantum.
// Result channel (out_valid/out_stall/out_data): exactly one result per item,
// in order. An output register parts the two sides, so the next item is
// taken while a result still waits for its transfer.
// Config port: APB-style, 3 registers at byte addresses 0, 4, 8; the user
// writes them only while idle, which the block does not enforce. pready is
// tied high. Order of work from the accepting edge: an arrival goes straight
// to the output register load. A tick first ages the queues, scanning one
// task at a time and moving each aged task up a level, then picks level by
// level (reading the head in the started-head search or past the limit),
// picks again after each drop, then runs the task (or reports idle) and loads
// the result. The task and link memories share one read port address.
// in_stall is high from acceptance until the result is handed to the output
// register. If the receiver stalls with a result already waiting, the
// finished result is held until the transfer. Reset (synchronous, rst_n low):
// queues empty, every slot free, tick 0, config at defaults; no memory clear.
module priority_scheduler_with_aging_core #(
  parameter int MAX_TASKS  = psa_pkg::MAX_TASKS_DEF,
  parameter int LEVELS     = psa_pkg::LEVELS_DEF,
  parameter int TICK_WIDTH = psa_pkg::TICK_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire psa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output psa_pkg::out_item_t      out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [3:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TW = 12 + TICK_WIDTH;

  typedef struct packed {
    logic [5:0]            id;
    logic [4:0]            remaining;
    logic                  started;
    logic [TICK_WIDTH-1:0] stamp;
  } task_t;

  typedef enum logic [3:0] {
    S_IDLE, S_AG_LV, S_AG_RD, S_AG_EV, S_AG_AP,
    S_PK, S_PR_RD, S_PR_EV, S_RN_RD, S_RN_EV, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  // config registers
  logic        preemptive_r;
  logic [7:0]  aging_wait_r;
  logic [15:0] admit_limit_r;

  // queue bookkeeping
  logic [SW-1:0]         head_r [LEVELS];
  logic [SW-1:0]         tail_r [LEVELS];
  logic [CW-1:0]         cnt_r  [LEVELS];
  logic [MAX_TASKS-1:0]  free_r;
  logic [TICK_WIDTH-1:0] tick_r;

  // walk context
  logic [LW-1:0] lv_r;
  logic [CW-1:0] k_r, n_r;
  logic [SW-1:0] cur_r, prev_r, nx_r;
  logic          prev_v_r;
  logic          np_mode_r;
  logic [6:0]    prom_r, drop_r;

  psa_pkg::out_item_t res_r, out_r;
  logic               out_valid_r;

  // memory ports
  logic          task_we, link_we, mem_re;
  logic [SW-1:0] task_waddr, link_waddr, mem_raddr;
  task_t         task_wdata, task_rd;
  logic [SW-1:0] link_wdata, link_rd;

  psa_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (task_rd)
  );

  psa_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (link_rd)
  );

  // ---------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------
  logic          in_xfer, arrive;
  logic [LW-1:0] arr_lv;
  logic [SW-1:0] free_idx;
  logic          any_free;
  logic          past_limit;
  logic          arr_ok;
  logic [7:0]    w_eff;
  logic          promote;
  logic [LW-1:0] up_lv;
  logic [4:0]    rem_dec;
  logic          run_fin;
  logic          all_empty;
  logic          lv_last;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign arrive   = in_xfer && (in_data.kind == psa_pkg::KIND_ARRIVAL);

  // out-of-range levels fold to the nearest end
  always_comb begin
    if (in_data.level == 3'd0) begin
      arr_lv = '0;
    end else if (int'(in_data.level) > LEVELS) begin
      arr_lv = LW'(LEVELS - 1);
    end else begin
      arr_lv = LW'(in_data.level - 3'd1);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = SW'(i);
        any_free = 1'b1;
      end
    end
  end

  assign past_limit = 32'(tick_r) >= 32'(admit_limit_r);
  assign arr_ok     = !past_limit && any_free;
  assign w_eff      = (aging_wait_r == 8'd0) ? 8'd1 : aging_wait_r;
  assign promote    = !task_rd.started &&
                      (({1'b0, task_rd.stamp} + (TICK_WIDTH + 1)'(w_eff)) <= {1'b0, tick_r});
  assign up_lv      = lv_r - LW'(1);
  assign rem_dec    = (task_rd.remaining != 5'd0) ? task_rd.remaining - 5'd1 : 5'd0;
  assign run_fin    = (rem_dec == 5'd0);
  assign lv_last    = (32'(lv_r) == LEVELS - 1);

  always_comb begin
    all_empty = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt_r[i] != '0) all_empty = 1'b0;
    end
  end

  // memory control
  always_comb begin
    task_we    = 1'b0;
    task_waddr = cur_r;
    task_wdata = task_rd;
    link_we    = 1'b0;
    link_waddr = prev_r;
    link_wdata = link_rd;
    mem_re     = 1'b0;
    mem_raddr  = cur_r;
    unique case (state_r)
      S_IDLE: begin
        if (arrive && arr_ok) begin
          task_we    = 1'b1;
          task_waddr = free_idx;
          task_wdata = '{id: in_data.task_id, remaining: in_data.service_quanta,
                         started: 1'b0, stamp: tick_r};
          link_we    = (cnt_r[arr_lv] != '0);
          link_waddr = tail_r[arr_lv];
          link_wdata = free_idx;
        end
      end
      S_AG_RD: begin
        mem_re = 1'b1;
      end
      S_AG_EV: begin
        if (promote) begin
          task_we          = 1'b1;
          task_wdata.stamp = tick_r;
          link_we          = prev_v_r;
        end
      end
      S_AG_AP: begin
        link_we    = (cnt_r[up_lv] != '0);
        link_waddr = tail_r[up_lv];
        link_wdata = cur_r;
      end
      S_PR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = head_r[lv_r];
      end
      S_RN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = head_r[lv_r];
      end
      S_RN_EV: begin
        task_we              = 1'b1;
        task_wdata.started   = 1'b1;
        task_wdata.remaining = rem_dec;
        link_we    = !run_fin && preemptive_r && (cnt_r[lv_r] > CW'(1));
        link_waddr = tail_r[lv_r];
        link_wdata = cur_r;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      preemptive_r  <= psa_pkg::PREEMPTIVE_RST;
      aging_wait_r  <= psa_pkg::AGING_WAIT_RST;
      admit_limit_r <= psa_pkg::ADMIT_LIMIT_RST;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      free_r      <= '1;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        unique case (cfg_paddr[3:2])
          psa_pkg::REG_PREEMPTIVE:  preemptive_r  <= cfg_pwdata[0];
          psa_pkg::REG_AGING_WAIT:  aging_wait_r  <= cfg_pwdata[7:0];
          psa_pkg::REG_ADMIT_LIMIT: admit_limit_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end

      // S_OUT reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          res_r  <= '{accepted: arrive && arr_ok, tick_now: 16'(tick_r), default: '0};
          prom_r <= '0;
          drop_r <= '0;
          if (arrive) begin
            if (arr_ok) begin
              free_r[free_idx] <= 1'b0;
              if (cnt_r[arr_lv] == '0) head_r[arr_lv] <= free_idx;
              tail_r[arr_lv] <= free_idx;
              cnt_r[arr_lv]  <= cnt_r[arr_lv] + CW'(1);
            end
            state_r <= S_OUT;
          end else if (in_xfer) begin
            lv_r    <= LW'(LEVELS - 1);
            state_r <= S_AG_LV;
          end
        end

        // aging walk, one queue at a time from the lowest priority
        S_AG_LV: begin
          n_r      <= cnt_r[lv_r];
          k_r      <= '0;
          cur_r    <= head_r[lv_r];
          prev_v_r <= 1'b0;
          if (cnt_r[lv_r] != '0) begin
            state_r <= S_AG_RD;
          end else if (lv_r == LW'(1)) begin
            lv_r      <= '0;
            np_mode_r <= !preemptive_r;
            state_r   <= S_PK;
          end else begin
            lv_r <= up_lv;
          end
        end

        S_AG_RD: state_r <= S_AG_EV;

        S_AG_EV: begin
          if (promote) begin
            if (!prev_v_r) head_r[lv_r] <= link_rd;
            if (tail_r[lv_r] == cur_r && prev_v_r) tail_r[lv_r] <= prev_r;
            cnt_r[lv_r] <= cnt_r[lv_r] - CW'(1);
            nx_r        <= link_rd;
            if (prom_r != psa_pkg::CNT_MAX) prom_r <= prom_r + 7'd1;
            state_r <= S_AG_AP;
          end else begin
            prev_r   <= cur_r;
            prev_v_r <= 1'b1;
            cur_r    <= link_rd;
            k_r      <= k_r + CW'(1);
            if (k_r + CW'(1) == n_r) begin
              if (lv_r == LW'(1)) begin
                lv_r      <= '0;
                np_mode_r <= !preemptive_r;
                state_r   <= S_PK;
              end else begin
                lv_r    <= up_lv;
                state_r <= S_AG_LV;
              end
            end else begin
              state_r <= S_AG_RD;
            end
          end
        end

        S_AG_AP: begin
          if (cnt_r[up_lv] == '0) head_r[up_lv] <= cur_r;
          tail_r[up_lv] <= cur_r;
          cnt_r[up_lv]  <= cnt_r[up_lv] + CW'(1);
          cur_r <= nx_r;
          k_r   <= k_r + CW'(1);
          if (k_r + CW'(1) == n_r) begin
            if (lv_r == LW'(1)) begin
              lv_r      <= '0;
              np_mode_r <= !preemptive_r;
              state_r   <= S_PK;
            end else begin
              lv_r    <= up_lv;
              state_r <= S_AG_LV;
            end
          end else begin
            state_r <= S_AG_RD;
          end
        end

        // pick: started-head search (non-preemptive), then first non-empty
        S_PK: begin
          if (cnt_r[lv_r] == '0) begin
            if (lv_last) begin
              if (np_mode_r) begin
                np_mode_r <= 1'b0;
                lv_r      <= '0;
              end else begin
                state_r <= S_FIN;
              end
            end else begin
              lv_r <= lv_r + LW'(1);
            end
          end else if (np_mode_r || past_limit) begin
            state_r <= S_PR_RD;
          end else begin
            state_r <= S_RN_RD;
          end
        end

        S_PR_RD: state_r <= S_PR_EV;

        S_PR_EV: begin
          if (np_mode_r) begin
            if (task_rd.started) begin
              state_r <= S_RN_RD;
            end else if (lv_last) begin
              np_mode_r <= 1'b0;
              lv_r      <= '0;
              state_r   <= S_PK;
            end else begin
              lv_r    <= lv_r + LW'(1);
              state_r <= S_PK;
            end
          end else if (!task_rd.started) begin
            // unstarted head past the limit: drop and pick again
            free_r[head_r[lv_r]] <= 1'b1;
            head_r[lv_r] <= link_rd;
            cnt_r[lv_r]  <= cnt_r[lv_r] - CW'(1);
            if (drop_r != psa_pkg::CNT_MAX) drop_r <= drop_r + 7'd1;
            lv_r      <= '0;
            np_mode_r <= !preemptive_r;
            state_r   <= S_PK;
          end else begin
            state_r <= S_RN_RD;
          end
        end

        S_RN_RD: begin
          cur_r   <= head_r[lv_r];
          state_r <= S_RN_EV;
        end

        S_RN_EV: begin
          res_r.run_id    <= task_rd.id;
          res_r.run_level <= 3'(lv_r) + 3'd1;
          res_r.first_run <= !task_rd.started;
          res_r.finished  <= run_fin;
          res_r.promoted  <= prom_r;
          res_r.dropped   <= drop_r;
          if (run_fin) begin
            free_r[cur_r] <= 1'b1;
            head_r[lv_r]  <= link_rd;
            cnt_r[lv_r]   <= cnt_r[lv_r] - CW'(1);
          end else if (preemptive_r && cnt_r[lv_r] > CW'(1)) begin
            head_r[lv_r] <= link_rd;
            tail_r[lv_r] <= cur_r;
          end
          if (tick_r != '1) tick_r <= tick_r + TICK_WIDTH'(1);
          state_r <= S_OUT;
        end

        S_FIN: begin
          res_r.idle     <= 1'b1;
          res_r.promoted <= prom_r;
          res_r.dropped  <= drop_r;
          res_r.all_done <= past_limit && all_empty;
          if (tick_r != '1) tick_r <= tick_r + TICK_WIDTH'(1);
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // config readback
  always_comb begin
    unique case (cfg_paddr[3:2])
      psa_pkg::REG_PREEMPTIVE:  cfg_prdata = {31'd0, preemptive_r};
      psa_pkg::REG_AGING_WAIT:  cfg_prdata = {24'd0, aging_wait_r};
      psa_pkg::REG_ADMIT_LIMIT: cfg_prdata = {16'd0, admit_limit_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end
  assign cfg_pready = 1'b1;

endmodule
`default_nettype wire

FILE: rtl/core/psa_ram.sv
`default_nettype none
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
